### design/lev_pkg.sv
package lev_pkg;

   localparam int TERM_W  = 48;
   localparam int ID_W    = 16;
   localparam int INDEX_W = 4;
   localparam int NVOTE_W = 5;
   localparam int TMO_W   = 15;
   localparam int TICK_W  = 16;
   localparam int CNT_W   = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   // wide enough to compare any voter position against the voter count
   localparam int POS_W   = 7;

   localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic [1:0] CMD_TICK       = 2'd0;
   localparam logic [1:0] CMD_START      = 2'd1;
   localparam logic [1:0] CMD_VOTE_REQ   = 2'd2;
   localparam logic [1:0] CMD_VOTE_RCVD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_VOTING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_INDEX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOTER_NUM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ELECT_TMO   = 3'd4;

   typedef struct packed {
      logic [1:0]         command;
      logic [ID_W-1:0]    cand_id;
      logic [TERM_W-1:0]  cand_last_index;
      logic [TERM_W-1:0]  cand_last_term;
      logic [TERM_W-1:0]  own_last_index;
      logic [TERM_W-1:0]  own_last_term;
      logic [INDEX_W-1:0] granter_pos;
      logic [TMO_W-1:0]   random_offset;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic               expired;
      logic               won;
      logic [CNT_W-1:0]   vote_count;
      logic [TERM_W-1:0]  term;
      logic               request_votes;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    self_id;
      logic               self_voting;
      logic [INDEX_W-1:0] self_index;
      logic [NVOTE_W-1:0] voter_num;
      logic [TMO_W-1:0]   base_timeout;
   } cfg_type;

endpackage

### design/lev_tally.sv
module lev_tally #(
   parameter int MAX_VOTERS = 16
) (
   input  logic [MAX_VOTERS-1:0]     vote_map,
   input  logic [lev_pkg::NVOTE_W-1:0] n_count,
   output logic [lev_pkg::CNT_W-1:0]   vote_count,
   output logic                        won
);
   import lev_pkg::*;

   logic [CNT_W-1:0] sum;

   // count only positions below the voter count
   always_comb begin
      sum = '0;
      for (int i = 0; i < MAX_VOTERS; i++) begin
         if (POS_W'(i) < {{(POS_W-NVOTE_W){1'b0}}, n_count}) begin
            sum = sum + CNT_W'(vote_map[i]);
         end
      end
   end

   assign vote_count = sum;
   assign won = (n_count != '0) && (sum >= (n_count >> 1) + CNT_W'(1));

endmodule

### design/lev_state.sv
module lev_state #(
   parameter int MAX_VOTERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  lev_pkg::req_type item,
   input  lev_pkg::cfg_type cfg,
   output lev_pkg::rsp_type result
);
   import lev_pkg::*;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_VOTERS);

   logic [TERM_W-1:0]     term_ff, term_in;
   logic [ID_W-1:0]       voted_ff, voted_in;
   logic [MAX_VOTERS-1:0] map_ff, map_in;
   logic [TICK_W-1:0]     elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]     timeout_ff, timeout_in;

   logic [NVOTE_W-1:0]    n_count;
   logic                  own_ok, voter_ok, log_ok, grant;
   logic [MAX_VOTERS-1:0] own_bit, voter_bit;
   logic [TMO_W-1:0]      offs_clamp;
   logic [CNT_W-1:0]      cnt;
   logic                  won;

   assign n_count = ({{(POS_W-NVOTE_W){1'b0}}, cfg.voter_num} > MAX_POS) ?
                    NVOTE_W'(MAX_POS) : cfg.voter_num;

   assign own_ok   = {1'b0, cfg.self_index} < n_count;
   assign voter_ok = {1'b0, item.granter_pos} < n_count;

   always_comb begin
      for (int i = 0; i < MAX_VOTERS; i++) begin
         own_bit[i]   = POS_W'(i) == {{(POS_W-INDEX_W){1'b0}}, cfg.self_index};
         voter_bit[i] = POS_W'(i) == {{(POS_W-INDEX_W){1'b0}}, item.granter_pos};
      end
   end

   // candidate log at least as current as the local one
   always_comb begin
      if (item.own_last_index == '0) begin
         log_ok = 1'b1;
      end else if (item.cand_last_term != item.own_last_term) begin
         log_ok = item.cand_last_term > item.own_last_term;
      end else begin
         log_ok = item.own_last_index <= item.cand_last_index;
      end
   end

   assign grant = cfg.self_voting && ((voted_ff == '0) || (voted_ff == item.cand_id))
                  && log_ok;

   assign offs_clamp = (item.random_offset < cfg.base_timeout) ?
                       item.random_offset : cfg.base_timeout;

   always_comb begin
      term_in    = term_ff;
      voted_in   = voted_ff;
      map_in     = map_ff;
      elapsed_in = elapsed_ff;
      timeout_in = timeout_ff;
      case (item.command)
         CMD_TICK: begin
            if (elapsed_ff != TICK_MAX) begin
               elapsed_in = elapsed_ff + TICK_W'(1);
            end
         end
         CMD_START: begin
            if (term_ff != TERM_MAX) begin
               term_in = term_ff + TERM_W'(1);
            end
            voted_in   = cfg.self_id;
            map_in     = own_ok ? own_bit : '0;
            timeout_in = {1'b0, cfg.base_timeout} + {1'b0, offs_clamp};
            elapsed_in = '0;
         end
         CMD_VOTE_REQ: begin
            if (grant) begin
               voted_in   = item.cand_id;
               elapsed_in = '0;
            end
         end
         CMD_VOTE_RCVD: begin
            if (voter_ok) begin
               map_in = map_ff | voter_bit;
            end
         end
         default: begin
         end
      endcase
   end

   lev_tally #(
      .MAX_VOTERS (MAX_VOTERS)
   ) u_tally (
      .vote_map   (map_in),
      .n_count    (n_count),
      .vote_count (cnt),
      .won        (won)
   );

   always_comb begin
      result.granted       = (item.command == CMD_VOTE_REQ) && grant;
      result.expired       = (item.command == CMD_TICK) && (elapsed_in >= timeout_ff);
      result.won           = won;
      result.vote_count    = cnt;
      result.term          = term_in;
      result.request_votes = item.command == CMD_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff    <= '0;
         voted_ff   <= '0;
         map_ff     <= '0;
         elapsed_ff <= '0;
         timeout_ff <= '0;
      end else if (advance) begin
         term_ff    <= term_in;
         voted_ff   <= voted_in;
         map_ff     <= map_in;
         elapsed_ff <= elapsed_in;
         timeout_ff <= timeout_in;
      end
   end

endmodule

### design/leader_election_vote_unit.sv
// Election timer and vote bookkeeping for one server of a replicated cluster.
// Events arrive on the req_ channel (valid/stall): tick, start election,
// vote request, vote received. Each event yields exactly one transfer on the
// rsp_ channel with grant, expiry, majority, vote count and current term.
// An accepted event is registered in the input register, processed by
// lev_state, and its result is loaded into the output register, which
// drives rsp_valid.
// Throughput: one event per clock while rsp_stall is low; the input and
// output registers form a two-stage pipeline and the state update is
// combinational logic (48-bit term compare/increment, vote-map popcount).
// When rsp_stall is high the output register holds its result and the
// input register can still take one more event; with both full, req_stall
// goes high until the receiver drains the result.
// Reset (synchronous) clears term, vote, vote map, tick counter and timeout,
// and loads the configuration defaults. The user must write configuration
// through csr_ while no event is in flight; the block does not enforce it.
module leader_election_vote_unit #(
   parameter int MAX_VOTERS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lev_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lev_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [lev_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lev_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lev_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff, result;
   logic    out_valid_ff, out_valid_in;
   logic    req_xfer, out_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SELF_ID:     cfg_in.self_id      = csr_wdata[ID_W-1:0];
            CSR_SELF_VOTING: cfg_in.self_voting  = csr_wdata[0];
            CSR_SELF_INDEX:  cfg_in.self_index   = csr_wdata[INDEX_W-1:0];
            CSR_VOTER_NUM:   cfg_in.voter_num    = csr_wdata[NVOTE_W-1:0];
            CSR_ELECT_TMO:   cfg_in.base_timeout = csr_wdata[TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // process the held event whenever the output register is free or draining
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   lev_state #(
      .MAX_VOTERS (MAX_VOTERS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_id      <= ID_W'(1);
         cfg_ff.self_voting  <= 1'b1;
         cfg_ff.self_index   <= '0;
         cfg_ff.voter_num    <= NVOTE_W'(1);
         cfg_ff.base_timeout <= TMO_W'(1000);
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
